// File: rtl/assert_macros.svh
// assertion helpers used by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// File: rtl/gcpp_pkg.sv
package gcpp_pkg;

	localparam int ADDR_BITS = 24;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int QCNT_W    = 3;

	// result kinds
	localparam logic [3:0] K_REG3D  = 4'd0;
	localparam logic [3:0] K_REG2D  = 4'd1;
	localparam logic [3:0] K_LINEAR = 4'd2;
	localparam logic [3:0] K_FB     = 4'd3;
	localparam logic [3:0] K_TEX    = 4'd4;
	localparam logic [3:0] K_SETUP  = 4'd5;
	localparam logic [3:0] K_VFIELD = 4'd6;
	localparam logic [3:0] K_BEGIN  = 4'd7;
	localparam logic [3:0] K_DRAW   = 4'd8;
	localparam logic [3:0] K_JUMP   = 4'd9;
	localparam logic [3:0] K_BAD    = 4'd10;

	// register indexes
	localparam logic [1:0] R_IS_BANSHEE = 2'd0;
	localparam logic [1:0] R_START_ADDR = 2'd1;
	localparam logic [1:0] R_LIN_LIMIT  = 2'd2;

	typedef struct packed {
		logic [3:0]  kind;
		logic [23:0] address;
		logic [31:0] payload;
	} result_t;

	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} pair_t;

	typedef struct packed {
		logic        is_banshee;
		logic [23:0] linear_limit;
		logic [23:0] start_address;
		logic        load_rp;
	} cfg_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

	// vertex slot to field id
	function automatic logic [3:0] slot_id(input logic [3:0] s);
		case (s)
			4'd0: slot_id = 4'd0;
			4'd1: slot_id = 4'd1;
			4'd2: slot_id = 4'd14;
			default: slot_id = s - 4'd1;
		endcase
	endfunction

	// slot enabled by vertex header bits
	function automatic logic slot_on(input logic [31:0] h, input logic [3:0] s);
		logic pc;
		pc = h[28];
		case (s)
			4'd0, 4'd1: slot_on = 1'b1;
			4'd2: slot_on = h[10] & pc;
			4'd3, 4'd4, 4'd5: slot_on = h[10] & ~pc;
			4'd6: slot_on = h[11] & ~pc;
			4'd7: slot_on = h[12];
			4'd8: slot_on = h[13];
			4'd9: slot_on = h[14];
			4'd10, 4'd11: slot_on = h[15];
			4'd12: slot_on = h[16];
			4'd13, 4'd14: slot_on = h[17];
			default: slot_on = 1'b0;
		endcase
	endfunction

endpackage

// File: rtl/gcpp_if.sv
interface gcpp_cmd_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface gcpp_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [23:0] address;
	logic [31:0] payload;
	logic        last;
	modport source (output valid, output kind, output address, output payload, output last,
		input ready);
	modport sink (input valid, input kind, input address, input payload, input last,
		output ready);
endinterface

// File: rtl/gcpp_front.sv
module gcpp_front (
	input  logic             clk,
	input  logic             arst_n,
	gcpp_cmd_if.sink         cmd,
	input  gcpp_pkg::cfg_t   cfg,
	input  logic             q_full,
	output logic             push,
	output gcpp_pkg::pair_t  pair
);

	localparam logic [3:0] PH_HEADER = 4'd0;
	localparam logic [3:0] PH_T1     = 4'd1;
	localparam logic [3:0] PH_T2     = 4'd2;
	localparam logic [3:0] PH_T3     = 4'd3;
	localparam logic [3:0] PH_T4     = 4'd4;
	localparam logic [3:0] PH_T4PAD  = 4'd5;
	localparam logic [3:0] PH_T5ADDR = 4'd6;
	localparam logic [3:0] PH_T5DATA = 4'd7;
	localparam logic [3:0] PH_T5OVER = 4'd8;

	logic [3:0]                    phase_q, phase_n;
	logic [31:0]                   hdr_q, hdr_n;
	logic [18:0]                   rem_q, rem_n;
	logic [13:0]                   mask_q, mask_n;
	logic [23:0]                   wa_q, wa_n;
	logic [gcpp_pkg::ADDR_BITS-1:0] rp_q, rp_n, ret_q, ret_n, rp_inc;
	logic [1:0]                    vcnt_q, vcnt_n;
	logic [3:0]                    fidx_q, fidx_n;
	logic [3:0]                    vleft_q, vleft_n;
	logic [1:0]                    nres;
	logic                          accept;
	logic [31:0]                   w;

	assign w      = cmd.word;
	assign cmd.ready = ~q_full;
	assign accept = cmd.valid & ~q_full;
	assign rp_inc = rp_q + gcpp_pkg::ADDR_BITS'(4);

	function automatic logic [3:0] reg_kind(input logic [23:0] a, input logic isb);
		reg_kind = (a[13] && isb) ? gcpp_pkg::K_REG2D : gcpp_pkg::K_REG3D;
	endfunction

	// decode one word
	always_comb begin
		logic [4:0]  b2;
		logic [3:0]  b4;
		logic [3:0]  s, ns;
		logic [1:0]  v;
		logic [23:0] a, tgt;
		logic [18:0] cnt;
		phase_n = phase_q;
		hdr_n   = hdr_q;
		rem_n   = rem_q;
		mask_n  = mask_q;
		wa_n    = wa_q;
		rp_n    = rp_inc;
		ret_n   = ret_q;
		vcnt_n  = vcnt_q;
		fidx_n  = fidx_q;
		vleft_n = vleft_q;
		nres    = 2'd0;
		pair    = '0;
		b2 = '0;
		b4 = '0;
		s = '0;
		ns = 4'd15;
		v = '0;
		a = '0;
		tgt = {w[27:6], 2'b00};
		cnt = w[21:3];
		case (phase_q)
			PH_T1: begin
				pair.r0 = '{reg_kind(wa_q, cfg.is_banshee), wa_q, w};
				nres = 2'd1;
				if (hdr_q[15]) wa_n = wa_q + 24'd4;
				rem_n = rem_q - 19'd1;
				if (rem_n == '0) phase_n = PH_HEADER;
			end
			PH_T2: begin
				for (int i = 28; i >= 0; i--)
					if (hdr_q[i]) b2 = 5'(i);
				pair.r0 = '{gcpp_pkg::K_REG2D, 24'd8 + {17'd0, b2, 2'b00}, w};
				nres = 2'd1;
				hdr_n = hdr_q & (hdr_q - 32'd1);
				if (hdr_n == '0) phase_n = PH_HEADER;
			end
			PH_T3: begin
				s = (fidx_q < 4'd15) ? fidx_q : 4'd0;
				pair.r0 = '{gcpp_pkg::K_VFIELD, {20'd0, gcpp_pkg::slot_id(s)}, w};
				nres = 2'd1;
				for (int t = 14; t >= 0; t--)
					if (4'(t) > s && gcpp_pkg::slot_on(hdr_q, 4'(t))) ns = 4'(t);
				if (ns != 4'd15) begin
					fidx_n = ns;
				end else begin
					pair.r1 = '{(vcnt_q != 2'd0) ? gcpp_pkg::K_DRAW : gcpp_pkg::K_BEGIN,
						24'd0, 32'd0};
					pair.two = 1'b1;
					nres = 2'd2;
					v = vcnt_q;
					if (v != 2'd3) v = v + 2'd1;
					if (v == 2'd3 && hdr_q[5:3] == 3'd0) v = 2'd0;
					vcnt_n = v;
					fidx_n = 4'd0;
					vleft_n = vleft_q - 4'd1;
					if (vleft_n == 4'd0) phase_n = PH_HEADER;
				end
			end
			PH_T4: begin
				for (int i = 13; i >= 0; i--)
					if (mask_q[i]) b4 = 4'(i);
				a = wa_q + {18'd0, b4, 2'b00};
				pair.r0 = '{reg_kind(a, cfg.is_banshee), a, w};
				nres = 2'd1;
				mask_n = mask_q & (mask_q - 14'd1);
				if (mask_n == '0) phase_n = (rem_q != '0) ? PH_T4PAD : PH_HEADER;
			end
			PH_T4PAD: begin
				rem_n = rem_q - 19'd1;
				if (rem_n == '0) phase_n = PH_HEADER;
			end
			PH_T5ADDR: begin
				wa_n = w[23:0];
				phase_n = PH_T5DATA;
			end
			PH_T5DATA, PH_T5OVER: begin
				if (hdr_q[31:30] == 2'd0) begin
					if (phase_q == PH_T5DATA && wa_q <= cfg.linear_limit) begin
						pair.r0 = '{gcpp_pkg::K_LINEAR, wa_q, w};
						nres = 2'd1;
					end
					if (wa_q >= 24'hfffffc) phase_n = PH_T5OVER;
				end else begin
					pair.r0 = '{(hdr_q[31:30] == 2'd2) ? gcpp_pkg::K_FB : gcpp_pkg::K_TEX,
						wa_q, w};
					nres = 2'd1;
				end
				wa_n = wa_q + 24'd4;
				rem_n = rem_q - 19'd1;
				if (rem_n == '0) phase_n = PH_HEADER;
			end
			default: begin
				phase_n = PH_HEADER;
				hdr_n = w;
				case (w[2:0])
					3'd0: begin
						case (w[5:3])
							3'd0: ;
							3'd1: begin
								ret_n = rp_inc;
								rp_n = tgt;
								pair.r0 = '{gcpp_pkg::K_JUMP, tgt, 32'd0};
								nres = 2'd1;
							end
							3'd2: begin
								rp_n = ret_q;
								pair.r0 = '{gcpp_pkg::K_JUMP, ret_q, 32'd0};
								nres = 2'd1;
							end
							3'd3: begin
								rp_n = tgt;
								pair.r0 = '{gcpp_pkg::K_JUMP, tgt, 32'd0};
								nres = 2'd1;
							end
							default: begin
								pair.r0 = '{gcpp_pkg::K_BAD, rp_inc, w};
								nres = 2'd1;
							end
						endcase
					end
					3'd1: begin
						rem_n = {3'd0, w[31:16]};
						wa_n = {10'd0, w[14:3], 2'b00};
						if (w[31:16] != '0) phase_n = PH_T1;
					end
					3'd2: begin
						if (!cfg.is_banshee) begin
							pair.r0 = '{gcpp_pkg::K_BAD, rp_inc, w};
							nres = 2'd1;
						end else begin
							hdr_n = {3'd0, w[31:3]};
							if (w[31:3] != '0) phase_n = PH_T2;
						end
					end
					3'd3: begin
						pair.r0 = '{gcpp_pkg::K_SETUP, 24'd0,
							{12'd0, w[25:22], 8'd0, w[17:10]}};
						nres = 2'd1;
						vleft_n = w[9:6];
						vcnt_n = (w[5:3] == 3'd2) ? 2'd1 : 2'd0;
						fidx_n = 4'd0;
						if (w[9:6] != 4'd0) phase_n = PH_T3;
					end
					3'd4: begin
						mask_n = w[28:15];
						wa_n = {10'd0, w[14:3], 2'b00};
						rem_n = {16'd0, w[31:29]};
						if (w[28:15] != '0) phase_n = PH_T4;
						else if (w[31:29] != '0) phase_n = PH_T4PAD;
					end
					3'd5: begin
						if (w[31:30] == 2'd1) begin
							pair.r0 = '{gcpp_pkg::K_BAD, rp_inc, w};
							nres = 2'd1;
						end else begin
							rem_n = (cnt != '0) ? cnt : 19'd1;
							phase_n = PH_T5ADDR;
						end
					end
					default: begin
						pair.r0 = '{gcpp_pkg::K_BAD, rp_inc, w};
						nres = 2'd1;
					end
				endcase
			end
		endcase
	end

	assign push = accept & (nres != 2'd0);

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q   <= '0;
			rem_q   <= '0;
			mask_q  <= '0;
			wa_q    <= '0;
			rp_q    <= '0;
			ret_q   <= '0;
			vcnt_q  <= '0;
			fidx_q  <= '0;
			vleft_q <= '0;
		end else if (cfg.load_rp) begin
			rp_q <= cfg.start_address;
		end else if (accept) begin
			phase_q <= phase_n;
			hdr_q   <= hdr_n;
			rem_q   <= rem_n;
			mask_q  <= mask_n;
			wa_q    <= wa_n;
			rp_q    <= rp_n;
			ret_q   <= ret_n;
			vcnt_q  <= vcnt_n;
			fidx_q  <= fidx_n;
			vleft_q <= vleft_n;
		end
	end

endmodule

// File: rtl/gcpp_queue.sv
module gcpp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gcpp_pkg::pair_t   din,
	input  logic              pop,
	output gcpp_pkg::pair_t   head,
	output gcpp_pkg::qstat_t  stat
);

	gcpp_pkg::pair_t                mem [gcpp_pkg::QDEPTH];
	logic [gcpp_pkg::QPTR_W-1:0]    wp_q, rp_q;
	logic [gcpp_pkg::QCNT_W-1:0]    cnt_q;

	assign head       = mem[rp_q];
	assign stat.count = cnt_q;
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == gcpp_pkg::QCNT_W'(gcpp_pkg::QDEPTH));

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + gcpp_pkg::QPTR_W'(1);
			if (pop) rp_q <= rp_q + gcpp_pkg::QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + gcpp_pkg::QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - gcpp_pkg::QCNT_W'(1);
		end
	end

endmodule

// File: rtl/gcpp_back.sv
module gcpp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  gcpp_pkg::pair_t  head,
	input  logic             empty,
	output logic             pop,
	gcpp_res_if.source       res
);

	logic            sel_q;
	gcpp_pkg::result_t cur;

	// pick the half of the entry being sent
	assign cur         = sel_q ? head.r1 : head.r0;
	assign res.valid   = ~empty;
	assign res.kind    = cur.kind;
	assign res.address = cur.address;
	assign res.payload = cur.payload;
	assign res.last    = sel_q | ~head.two;
	assign pop         = res.valid & res.ready & res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (res.valid && res.ready) begin
			sel_q <= ~res.last;
		end
	end

endmodule

// File: rtl/graphics_command_packet_parser.sv
// Command-stream packet decoder. One 32-bit word is taken per cycle while the
// result queue (four entries, each holding the one or two results of a word)
// has room; words that yield no result are taken too. Results leave one per cycle
// while the sink is ready; a vertex's last word yields two (field, begin or draw).
// The front keeps accepting until the queue fills. At byte offsets 0, 4 and 8 sit
// is_banshee, start_address (which also reloads the fetch pointer) and linear_limit;
// the user must write them over APB only while idle; the block does not enforce it.
`include "assert_macros.svh"
module graphics_command_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	gcpp_cmd_if.sink    cmd,
	gcpp_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                 isb_q;
	logic [23:0]          start_q, limit_q;
	logic                 wr;
	gcpp_pkg::cfg_t       cfg;
	gcpp_pkg::pair_t      pair, head;
	gcpp_pkg::qstat_t     stat;
	logic                 push, pop;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isb_q   <= 1'b0;
			start_q <= '0;
			limit_q <= 24'hffffff;
		end else if (wr) begin
			case (paddr[3:2])
				gcpp_pkg::R_IS_BANSHEE: isb_q <= pwdata[0];
				gcpp_pkg::R_START_ADDR: start_q <= pwdata[23:0];
				gcpp_pkg::R_LIN_LIMIT: limit_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			gcpp_pkg::R_IS_BANSHEE: prdata = {31'd0, isb_q};
			gcpp_pkg::R_START_ADDR: prdata = {8'd0, start_q};
			gcpp_pkg::R_LIN_LIMIT: prdata = {8'd0, limit_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.is_banshee    = isb_q;
	assign cfg.linear_limit  = limit_q;
	assign cfg.start_address = pwdata[23:0];
	assign cfg.load_rp       = wr && (paddr[3:2] == gcpp_pkg::R_START_ADDR);

	gcpp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.q_full (stat.full),
		.push   (push),
		.pair   (pair)
	);

	gcpp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (pair),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	gcpp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (stat.empty),
		.pop    (pop),
		.res    (res)
	);

	`ASSERT_ALWAYS(a_no_push_full, clk, arst_n, !(push && stat.full), "push into full queue")
	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, stat.count <= 3'(gcpp_pkg::QDEPTH), "count range")
	`ASSERT_NEXT(a_push_fill, clk, arst_n, push && !pop, stat.count == $past(stat.count) + 3'd1, "count lost a push")

endmodule
